[hw/rtl/psg_pkg.sv]
// ----------------------------------------------------------------------------
// psg_pkg
// Shared types and constants of the three-channel sound generator.
// ----------------------------------------------------------------------------
package psg_pkg;

  // channel count
  localparam int unsigned NUM_CH_MAX       = 3;
  localparam int unsigned NUM_CHANNELS_DEF = 3;

  // field widths
  localparam int unsigned DATA_W      = 8;
  localparam int unsigned LEVEL_W     = 4;
  localparam int unsigned TONE_W      = 12;
  localparam int unsigned NOISE_PER_W = 5;
  localparam int unsigned NOISE_CNT_W = NOISE_PER_W + 1;
  localparam int unsigned LFSR_W      = 16;
  localparam int unsigned ENV_PER_W   = 16;
  localparam int unsigned ENV_CNT_W   = ENV_PER_W + 1;

  // envelope levels
  localparam logic [LEVEL_W-1:0] ENV_MAX = 4'hF;
  localparam logic [LEVEL_W-1:0] ENV_MIN = 4'h0;

  // value returned for an unimplemented register
  localparam logic [DATA_W-1:0] READ_NONE = 8'hFF;

  // amplitude register: envelope select bit
  localparam int unsigned AMP_ENV_BIT = 4;

  // envelope shape bits
  localparam int unsigned SHAPE_HOLD   = 0;
  localparam int unsigned SHAPE_ALT    = 1;
  localparam int unsigned SHAPE_ATTACK = 2;
  localparam int unsigned SHAPE_CONT   = 3;

  // request kinds
  typedef enum logic [1:0] {
    KIND_TICK  = 2'd0,
    KIND_LATCH = 2'd1,
    KIND_WRITE = 2'd2,
    KIND_READ  = 2'd3
  } psg_kind_e;

  // register addresses
  localparam logic [DATA_W-1:0] REG_TONE_A_LO = 8'd0;
  localparam logic [DATA_W-1:0] REG_TONE_A_HI = 8'd1;
  localparam logic [DATA_W-1:0] REG_TONE_B_LO = 8'd2;
  localparam logic [DATA_W-1:0] REG_TONE_B_HI = 8'd3;
  localparam logic [DATA_W-1:0] REG_TONE_C_LO = 8'd4;
  localparam logic [DATA_W-1:0] REG_TONE_C_HI = 8'd5;
  localparam logic [DATA_W-1:0] REG_NOISE     = 8'd6;
  localparam logic [DATA_W-1:0] REG_MIXER     = 8'd7;
  localparam logic [DATA_W-1:0] REG_AMP_A     = 8'd8;
  localparam logic [DATA_W-1:0] REG_AMP_B     = 8'd9;
  localparam logic [DATA_W-1:0] REG_AMP_C     = 8'd10;
  localparam logic [DATA_W-1:0] REG_ENV_LO    = 8'd11;
  localparam logic [DATA_W-1:0] REG_ENV_HI    = 8'd12;
  localparam logic [DATA_W-1:0] REG_ENV_SHAPE = 8'd13;

  // per-request control strobes
  typedef struct packed {
    logic              tick;
    logic              latch_wr;
    logic              data_wr;
    logic              shape_wr;
    logic [DATA_W-1:0] data;
  } psg_ctrl_t;

  // register file contents seen by the generators
  typedef struct packed {
    logic [DATA_W-1:0]                    addr;
    logic [NUM_CH_MAX-1:0][ENV_PER_W-1:0] tone_div;
    logic [DATA_W-1:0]                    noise_div;
    logic [DATA_W-1:0]                    mixer;
    logic [NUM_CH_MAX-1:0][DATA_W-1:0]    amp;
    logic [ENV_PER_W-1:0]                 env_period;
  } psg_regs_t;

endpackage

[hw/rtl/psg_regs.sv]
// ----------------------------------------------------------------------------
// psg_regs
// Address latch, byte-wide register file and read-back multiplexer.
// ----------------------------------------------------------------------------
module psg_regs (
  input  logic                       clk_i,
  input  logic                       rst_ni,
  input  psg_pkg::psg_ctrl_t         ctrl_i,
  input  logic [psg_pkg::DATA_W-1:0] env_shape_i,
  output psg_pkg::psg_regs_t         regs_o,
  output logic [psg_pkg::DATA_W-1:0] read_data_o
);

  psg_pkg::psg_regs_t regs_d, regs_q;

  // latch and data writes
  always_comb begin
    regs_d = regs_q;
    if (ctrl_i.latch_wr) begin
      regs_d.addr = ctrl_i.data;
    end else if (ctrl_i.data_wr) begin
      unique case (regs_q.addr)
        psg_pkg::REG_TONE_A_LO: regs_d.tone_div[0][7:0]  = ctrl_i.data;
        psg_pkg::REG_TONE_A_HI: regs_d.tone_div[0][15:8] = ctrl_i.data;
        psg_pkg::REG_TONE_B_LO: regs_d.tone_div[1][7:0]  = ctrl_i.data;
        psg_pkg::REG_TONE_B_HI: regs_d.tone_div[1][15:8] = ctrl_i.data;
        psg_pkg::REG_TONE_C_LO: regs_d.tone_div[2][7:0]  = ctrl_i.data;
        psg_pkg::REG_TONE_C_HI: regs_d.tone_div[2][15:8] = ctrl_i.data;
        psg_pkg::REG_NOISE:     regs_d.noise_div         = ctrl_i.data;
        psg_pkg::REG_MIXER:     regs_d.mixer             = ctrl_i.data;
        psg_pkg::REG_AMP_A:     regs_d.amp[0]            = ctrl_i.data;
        psg_pkg::REG_AMP_B:     regs_d.amp[1]            = ctrl_i.data;
        psg_pkg::REG_AMP_C:     regs_d.amp[2]            = ctrl_i.data;
        psg_pkg::REG_ENV_LO:    regs_d.env_period[7:0]   = ctrl_i.data;
        psg_pkg::REG_ENV_HI:    regs_d.env_period[15:8]  = ctrl_i.data;
        default: ;  // shape lives in the envelope unit, others unimplemented
      endcase
    end
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      regs_q <= '0;
    end else begin
      regs_q <= regs_d;
    end
  end

  // read-back of the latched register
  always_comb begin
    unique case (regs_q.addr)
      psg_pkg::REG_TONE_A_LO: read_data_o = regs_q.tone_div[0][7:0];
      psg_pkg::REG_TONE_A_HI: read_data_o = regs_q.tone_div[0][15:8];
      psg_pkg::REG_TONE_B_LO: read_data_o = regs_q.tone_div[1][7:0];
      psg_pkg::REG_TONE_B_HI: read_data_o = regs_q.tone_div[1][15:8];
      psg_pkg::REG_TONE_C_LO: read_data_o = regs_q.tone_div[2][7:0];
      psg_pkg::REG_TONE_C_HI: read_data_o = regs_q.tone_div[2][15:8];
      psg_pkg::REG_NOISE:     read_data_o = regs_q.noise_div;
      psg_pkg::REG_MIXER:     read_data_o = regs_q.mixer;
      psg_pkg::REG_AMP_A:     read_data_o = regs_q.amp[0];
      psg_pkg::REG_AMP_B:     read_data_o = regs_q.amp[1];
      psg_pkg::REG_AMP_C:     read_data_o = regs_q.amp[2];
      psg_pkg::REG_ENV_LO:    read_data_o = regs_q.env_period[7:0];
      psg_pkg::REG_ENV_HI:    read_data_o = regs_q.env_period[15:8];
      psg_pkg::REG_ENV_SHAPE: read_data_o = env_shape_i;
      default:                read_data_o = psg_pkg::READ_NONE;
    endcase
  end

  assign regs_o = regs_q;

endmodule

[hw/rtl/psg_tone.sv]
// ----------------------------------------------------------------------------
// psg_tone
// One tone channel: 12-bit period counter and square-wave output bit.
// ----------------------------------------------------------------------------
module psg_tone (
  input  logic                          clk_i,
  input  logic                          rst_ni,
  input  logic                          tick_i,
  input  logic [psg_pkg::ENV_PER_W-1:0] period_i,
  output logic                          tone_bit_o
);

  logic [psg_pkg::TONE_W-1:0] cnt_d, cnt_q;
  logic [psg_pkg::TONE_W:0]   cnt_inc;
  logic                       fire;
  logic                       bit_d, bit_q;

  // count up, wrap at the period and toggle the output
  always_comb begin
    cnt_inc = {1'b0, cnt_q} + 1'b1;
    fire    = cnt_inc >= {1'b0, period_i[psg_pkg::TONE_W-1:0]};
    cnt_d   = cnt_q;
    bit_d   = bit_q;
    if (tick_i) begin
      cnt_d = fire ? '0 : cnt_inc[psg_pkg::TONE_W-1:0];
      bit_d = fire ? ~bit_q : bit_q;
    end
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      cnt_q <= '0;
      bit_q <= 1'b0;
    end else begin
      cnt_q <= cnt_d;
      bit_q <= bit_d;
    end
  end

  assign tone_bit_o = bit_d;

endmodule

[hw/rtl/psg_noise.sv]
// ----------------------------------------------------------------------------
// psg_noise
// Noise period counter and 16-bit shift register noise source.
// ----------------------------------------------------------------------------
module psg_noise (
  input  logic                       clk_i,
  input  logic                       rst_ni,
  input  logic                       tick_i,
  input  logic [psg_pkg::DATA_W-1:0] period_i,
  output logic                       noise_bit_o
);

  logic [psg_pkg::NOISE_CNT_W-1:0] cnt_d, cnt_q;
  logic [psg_pkg::NOISE_CNT_W:0]   cnt_inc;
  logic [psg_pkg::NOISE_CNT_W-1:0] limit;
  logic                            fire;
  logic [psg_pkg::LFSR_W-1:0]      shift_d, shift_q;
  logic                            bit_d, bit_q;

  // counter limit is twice the 5-bit period
  assign limit = {period_i[psg_pkg::NOISE_PER_W-1:0], 1'b0};

  // step the shift register on each counter wrap
  always_comb begin
    cnt_inc = {1'b0, cnt_q} + 1'b1;
    fire    = cnt_inc >= {1'b0, limit};
    cnt_d   = cnt_q;
    shift_d = shift_q;
    bit_d   = bit_q;
    if (tick_i) begin
      cnt_d = fire ? '0 : cnt_inc[psg_pkg::NOISE_CNT_W-1:0];
      if (fire) begin
        shift_d = {shift_q[psg_pkg::LFSR_W-2:0], ~(bit_q ^ shift_q[13])};
        bit_d   = shift_q[psg_pkg::LFSR_W-1];
      end
    end
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      cnt_q   <= '0;
      shift_q <= '0;
      bit_q   <= 1'b0;
    end else begin
      cnt_q   <= cnt_d;
      shift_q <= shift_d;
      bit_q   <= bit_d;
    end
  end

  assign noise_bit_o = bit_d;

endmodule

[hw/rtl/psg_env.sv]
// ----------------------------------------------------------------------------
// psg_env
// Envelope generator: 17-bit period counter, level ramp and shape register.
// ----------------------------------------------------------------------------
module psg_env (
  input  logic                           clk_i,
  input  logic                           rst_ni,
  input  psg_pkg::psg_ctrl_t             ctrl_i,
  input  logic [psg_pkg::ENV_PER_W-1:0]  period_i,
  output logic [psg_pkg::LEVEL_W-1:0]    level_o,
  output logic [psg_pkg::DATA_W-1:0]     shape_o
);

  logic [psg_pkg::ENV_CNT_W-1:0] cnt_d, cnt_q;
  logic [psg_pkg::ENV_CNT_W:0]   cnt_inc;
  logic                          fire;
  logic [psg_pkg::LEVEL_W-1:0]   level_d, level_q;
  logic [psg_pkg::LEVEL_W-1:0]   end_level;
  logic                          hold_d, hold_q;
  logic [psg_pkg::DATA_W-1:0]    shape_d, shape_q;

  assign cnt_inc   = {1'b0, cnt_q} + 1'b1;
  assign fire      = cnt_inc >= {1'b0, period_i, 1'b0};
  assign end_level = shape_q[psg_pkg::SHAPE_ATTACK] ? psg_pkg::ENV_MAX : psg_pkg::ENV_MIN;

  // shape write restarts, tick ramps the level and applies the end rules
  always_comb begin
    cnt_d   = cnt_q;
    level_d = level_q;
    hold_d  = hold_q;
    shape_d = shape_q;
    if (ctrl_i.shape_wr) begin
      shape_d = ctrl_i.data;
      hold_d  = 1'b0;
      level_d = ctrl_i.data[psg_pkg::SHAPE_ATTACK] ? psg_pkg::ENV_MIN : psg_pkg::ENV_MAX;
    end else if (ctrl_i.tick) begin
      cnt_d = fire ? '0 : cnt_inc[psg_pkg::ENV_CNT_W-1:0];
      if (fire && !hold_q) begin
        if (level_q != end_level) begin
          level_d = shape_q[psg_pkg::SHAPE_ATTACK] ? level_q + 1'b1 : level_q - 1'b1;
        end else begin
          hold_d = 1'b1;
          priority if (!shape_q[psg_pkg::SHAPE_CONT]) begin
            level_d = psg_pkg::ENV_MIN;
          end else if (shape_q[psg_pkg::SHAPE_HOLD]) begin
            if (shape_q[psg_pkg::SHAPE_ALT]) begin
              level_d = ~level_q;
            end
          end else begin
            // repeating shapes: restart ramp, alternate turns direction
            if (!shape_q[psg_pkg::SHAPE_ALT]) begin
              level_d = ~level_q;
            end else begin
              shape_d[psg_pkg::SHAPE_ATTACK] = ~shape_q[psg_pkg::SHAPE_ATTACK];
            end
            hold_d = 1'b0;
          end
        end
      end
    end
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      cnt_q   <= '0;
      level_q <= '0;
      hold_q  <= 1'b0;
      shape_q <= '0;
    end else begin
      cnt_q   <= cnt_d;
      level_q <= level_d;
      hold_q  <= hold_d;
      shape_q <= shape_d;
    end
  end

  assign level_o = level_d;
  assign shape_o = shape_q;

endmodule

[hw/rtl/psg_tone_noise_envelope.sv]
// ----------------------------------------------------------------------------
// psg_tone_noise_envelope
// Three-channel tone, noise and envelope sound generator, top level.
// ----------------------------------------------------------------------------
// Each request is a tick, an address latch write, a data write or a data
// read. One request is taken per clock while in_stall_o is low; a request
// sits in an input register, from which the register file, tone, noise and
// envelope units update as it moves on, and the result of a tick or read
// lands in an output register, from which it is valid on the output and can
// be taken when the output is not stalled.
// Writes and latch writes give no result. The output register lets the next
// request go through while an earlier result waits; in_stall_o rises only
// when the input register holds a tick or read and the output register is
// full and stalled. Channels at or above NUM_CHANNELS are not built and
// always give level 0.
module psg_tone_noise_envelope #(
  parameter int unsigned NUM_CHANNELS = psg_pkg::NUM_CHANNELS_DEF
) (
  input  logic                        clk_i,
  input  logic                        rst_ni,
  input  logic                        in_valid_i,
  output logic                        in_stall_o,
  input  logic [1:0]                  kind_i,
  input  logic [psg_pkg::DATA_W-1:0]  bus_data_i,
  output logic                        out_valid_o,
  input  logic                        out_stall_i,
  output logic [psg_pkg::LEVEL_W-1:0] level_a_o,
  output logic [psg_pkg::LEVEL_W-1:0] level_b_o,
  output logic [psg_pkg::LEVEL_W-1:0] level_c_o,
  output logic [psg_pkg::DATA_W-1:0]  read_data_o,
  output logic                        is_read_o
);

  localparam int unsigned NCH = psg_pkg::NUM_CH_MAX;

  // input register
  logic                      in_vld_q;
  psg_pkg::psg_kind_e        kind_q;
  logic [psg_pkg::DATA_W-1:0] data_q;
  logic                      in_accept;
  logic                      has_result;
  logic                      advance;

  // output register
  logic                                 out_vld_d, out_vld_q;
  logic                                 out_load;
  logic [NCH-1:0][psg_pkg::LEVEL_W-1:0] lvl_d, lvl_q;
  logic [psg_pkg::DATA_W-1:0]           rdata_d, rdata_q;
  logic                                 is_read_d, is_read_q;

  // unit connections
  psg_pkg::psg_ctrl_t          ctrl;
  psg_pkg::psg_regs_t          regs;
  logic [psg_pkg::DATA_W-1:0]  env_shape;
  logic [psg_pkg::DATA_W-1:0]  reg_rdata;
  logic [psg_pkg::LEVEL_W-1:0] env_level;
  logic [NCH-1:0]              tone_bit;
  logic                        noise_bit;
  logic                        kind_tick, kind_read;

  // request moves on unless it owes a result and the output is blocked
  assign kind_tick  = kind_q == psg_pkg::KIND_TICK;
  assign kind_read  = kind_q == psg_pkg::KIND_READ;
  assign has_result = kind_tick || kind_read;
  assign advance    = in_vld_q && (!has_result || !out_vld_q || !out_stall_i);
  assign in_stall_o = in_vld_q && !advance;
  assign in_accept  = in_valid_i && !in_stall_o;

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      in_vld_q <= 1'b0;
    end else if (in_accept) begin
      in_vld_q <= 1'b1;
    end else if (advance) begin
      in_vld_q <= 1'b0;
    end
  end

  always_ff @(posedge clk_i) begin
    if (in_accept) begin
      kind_q <= psg_pkg::psg_kind_e'(kind_i);
      data_q <= bus_data_i;
    end
  end

  // strobes for the units
  always_comb begin
    ctrl.tick     = advance && kind_tick;
    ctrl.latch_wr = advance && (kind_q == psg_pkg::KIND_LATCH);
    ctrl.data_wr  = advance && (kind_q == psg_pkg::KIND_WRITE);
    ctrl.shape_wr = ctrl.data_wr && (regs.addr == psg_pkg::REG_ENV_SHAPE);
    ctrl.data     = data_q;
  end

  psg_regs u_regs (
    .clk_i       (clk_i),
    .rst_ni      (rst_ni),
    .ctrl_i      (ctrl),
    .env_shape_i (env_shape),
    .regs_o      (regs),
    .read_data_o (reg_rdata)
  );

  psg_noise u_noise (
    .clk_i       (clk_i),
    .rst_ni      (rst_ni),
    .tick_i      (ctrl.tick),
    .period_i    (regs.noise_div),
    .noise_bit_o (noise_bit)
  );

  psg_env u_env (
    .clk_i    (clk_i),
    .rst_ni   (rst_ni),
    .ctrl_i   (ctrl),
    .period_i (regs.env_period),
    .level_o  (env_level),
    .shape_o  (env_shape)
  );

  // tone channels and mixer
  for (genvar c = 0; c < NCH; c++) begin : g_ch
    if (c < NUM_CHANNELS) begin : g_on
      logic                        sig;
      logic [psg_pkg::LEVEL_W-1:0] amp;

      psg_tone u_tone (
        .clk_i      (clk_i),
        .rst_ni     (rst_ni),
        .tick_i     (ctrl.tick),
        .period_i   (regs.tone_div[c]),
        .tone_bit_o (tone_bit[c])
      );

      assign sig = (regs.mixer[c] | tone_bit[c]) & (regs.mixer[c+NCH] | noise_bit);
      assign amp = regs.amp[c][psg_pkg::AMP_ENV_BIT] ? env_level
                                                     : regs.amp[c][psg_pkg::LEVEL_W-1:0];
      assign lvl_d[c] = (sig && kind_tick) ? amp : '0;
    end else begin : g_off
      assign tone_bit[c] = 1'b0;
      assign lvl_d[c]    = tone_bit[c] ? env_level : '0;
    end
  end

  // result payload
  assign rdata_d   = kind_read ? reg_rdata : '0;
  assign is_read_d = kind_read;
  assign out_load  = advance && has_result;
  assign out_vld_d = out_load || (out_vld_q && out_stall_i);

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      out_vld_q <= 1'b0;
    end else begin
      out_vld_q <= out_vld_d;
    end
  end

  always_ff @(posedge clk_i) begin
    if (out_load) begin
      lvl_q     <= lvl_d;
      rdata_q   <= rdata_d;
      is_read_q <= is_read_d;
    end
  end

  assign out_valid_o = out_vld_q;
  assign level_a_o   = lvl_q[0];
  assign level_b_o   = lvl_q[1];
  assign level_c_o   = lvl_q[2];
  assign read_data_o = rdata_q;
  assign is_read_o   = is_read_q;

endmodule
